// ===== hw/rtl/mcau_pkg.sv =====
// Shared types, constants and helpers for the magnetometer calibrate and average unit.
// No dependencies; imported by mcau_div and magnetometer_calibrate_and_average_unit.
package mcau_pkg;

  localparam int DATA_W   = 32;
  localparam int RAW_W    = 16;
  localparam int COEF_W   = 24;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_PER_LSB = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z       = 3'd6;

  localparam logic signed [63:0] DATA_MAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] DATA_MIN64 = 64'shFFFF_FFFF_8000_0000;

  typedef logic signed [DATA_W-1:0] data_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic data_t sat_data(input logic signed [63:0] v);
    data_t r;
    if (v > DATA_MAX64) begin
      r = data_t'(DATA_MAX64);
    end else if (v < DATA_MIN64) begin
      r = data_t'(DATA_MIN64);
    end else begin
      r = data_t'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mcau_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the window sample store.
module mcau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/mcau_div.sv =====
// Iterative signed-by-small-unsigned divider, four quotient bits per cycle,
// truncating toward zero with a saturated 32-bit result. Depends on mcau_pkg.
module mcau_div import mcau_pkg::*; #(
  parameter int SUM_W  = 36,
  parameter int FILL_W = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [FILL_W-1:0]       divisor,
  output logic                    done,
  output data_t                   quotient
);

  localparam int RADIX_BITS = 4;
  localparam int DIV_W  = ((SUM_W + RADIX_BITS - 1) / RADIX_BITS) * RADIX_BITS;
  localparam int N_ITER = DIV_W / RADIX_BITS;
  localparam int CNT_W  = $clog2(N_ITER + 1);
  localparam int REM_W  = FILL_W + 1;

  logic [DIV_W-1:0]  mag_r, mag_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [FILL_W-1:0] div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              neg_r;
  logic [SUM_W-1:0]  abs_w;
  logic signed [DIV_W:0] q_signed;

  assign abs_w = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

  // Restoring division, RADIX_BITS bits per cycle. The remainder stays below the
  // divisor, so it needs only one bit more than the fill count.
  always_comb begin
    logic [REM_W-1:0] rem_t;
    logic [DIV_W-1:0] mag_t;
    rem_t = rem_r;
    mag_t = mag_r;
    for (int i = 0; i < RADIX_BITS; i++) begin
      rem_t = {rem_t[REM_W-2:0], mag_t[DIV_W-1]};
      mag_t = {mag_t[DIV_W-2:0], 1'b0};
      if (rem_t >= {1'b0, div_r}) begin
        rem_t    = rem_t - {1'b0, div_r};
        mag_t[0] = 1'b1;
      end
    end
    rem_nxt = rem_t;
    mag_nxt = mag_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(N_ITER);
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= DIV_W'(abs_w);
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r && (cnt_r != '0)) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = busy_r && (cnt_r == '0);
  assign q_signed = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  assign quotient = sat_data(64'(q_signed));

endmodule

// ===== hw/rtl/magnetometer_calibrate_and_average_unit.sv =====
// Top level of the magnetometer calibrate and average unit: sequencer, shared
// multiplier, window store and running sums. Depends on mcau_pkg, mcau_ram, mcau_div.

// The unit takes one raw three-axis sample per input transaction and returns one
// corrected three-axis result per transaction, all in signed Q16.16 saturated to
// 32 bits. Each axis is scaled by unit_per_lsb, optionally reduced by its hard-iron
// offset and optionally multiplied by its soft-iron gain; with averaging enabled the
// value enters a per-axis window of WINDOW entries and the result is the mean of the
// entries held so far, truncated toward zero. The axes are processed one after the
// other through a single 33 by 25 bit multiplier and one small divider, so in_ready
// is high only between samples. Per axis the sequencer steps through scaling and
// hard-iron correction (S_SCALE, S_HARD), the soft-iron product and its saturation
// when soft-iron is on (S_SOFT, S_SOFTSAT), a closing step (S_POST) and, with
// averaging, the window access (S_WIN, S_WRD) and the divider (S_DIV); the idle state
// accepts the sample and S_OUT hands the result to the output register.
// The output register lets the next sample be accepted while a result waits. There
// is no clearing pass: the window only ever reads entries it has written.
// Configuration writes are always accepted and must only be issued while the unit
// is idle.
module magnetometer_calibrate_and_average_unit import mcau_pkg::*; #(
  parameter int WINDOW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  // Sample input channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [RAW_W-1:0] in_raw_x,
  input  logic signed [RAW_W-1:0] in_raw_y,
  input  logic signed [RAW_W-1:0] in_raw_z,
  input  logic                 in_average_enable,
  input  logic                 in_hard_iron_enable,
  input  logic                 in_soft_iron_enable,
  // Result output channel.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DATA_W-1:0] out_field_x,
  output logic signed [DATA_W-1:0] out_field_y,
  output logic signed [DATA_W-1:0] out_field_z
);

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int HEAD_W = $clog2(WINDOW);
  localparam int SUM_W  = DATA_W + $clog2(WINDOW) + 1;
  localparam int DEPTH  = 3 * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int MUL_A_W = DATA_W + 1;
  localparam int MUL_B_W = COEF_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCALE   = 4'd1;
  localparam logic [3:0] S_HARD    = 4'd2;
  localparam logic [3:0] S_SOFT    = 4'd3;
  localparam logic [3:0] S_SOFTSAT = 4'd4;
  localparam logic [3:0] S_POST    = 4'd5;
  localparam logic [3:0] S_WIN     = 4'd6;
  localparam logic [3:0] S_WRD     = 4'd7;
  localparam logic [3:0] S_DIV     = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  // Configuration registers.
  logic [COEF_W-1:0] unit_r;
  data_t             offset_r [3];
  logic [COEF_W-1:0] gain_r [3];

  // Sequencer and window control.
  logic [3:0]        state_r, state_nxt;
  logic [1:0]        ax_r;
  logic [FILL_W-1:0] fill_r;
  logic [HEAD_W-1:0] head_r;
  logic signed [SUM_W-1:0] sum_r [3];
  logic              out_valid_r;

  // Sample and datapath registers.
  logic signed [RAW_W-1:0] raw_r [3];
  logic              avg_r, hard_r, soft_r;
  logic signed [PROD_W-1:0] prod_r;
  data_t             val_r;
  data_t             res_r [3];
  data_t             out_x_r, out_y_r, out_z_r;

  // Combinational datapath.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  data_t             scaled_val, hard_val, soft_val;
  logic              full, last, out_free, axis_done, accept;
  logic [FILL_W-1:0] fill_div;
  logic [ADDR_W-1:0] win_addr;
  logic [DATA_W-1:0] win_rd;
  logic signed [SUM_W-1:0] sum_nxt, old_ext;
  logic              div_start, div_done;
  data_t             div_q;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign last      = (ax_r == AXIS_LAST);
  assign full      = (fill_r == FILL_W'(WINDOW));
  assign fill_div  = full ? FILL_W'(WINDOW) : fill_r + 1'b1;
  assign axis_done = ((state_r == S_POST) && !avg_r) || ((state_r == S_DIV) && div_done);

  // The one multiplier serves the raw scaling and the soft-iron gain.
  always_comb begin
    if (state_r == S_SOFT) begin
      mul_a = MUL_A_W'(val_r);
      mul_b = $signed({1'b0, gain_r[ax_r]});
    end else begin
      mul_a = MUL_A_W'(raw_r[ax_r]);
      mul_b = $signed({1'b0, unit_r});
    end
  end
  assign mul_p = mul_a * mul_b;

  // Hard iron subtracts from the already saturated scaled value; soft iron keeps
  // the floor of the Q16.16 product by an arithmetic shift.
  assign scaled_val = sat_data(64'(prod_r));
  assign hard_val   = hard_r ? sat_data(64'(scaled_val) - 64'(offset_r[ax_r])) : scaled_val;
  assign soft_val   = sat_data(64'(prod_r >>> FRAC_W));

  // Window store: one row of WINDOW entries per axis.
  assign win_addr = ADDR_W'(ax_r) * ADDR_W'(WINDOW) + ADDR_W'(head_r);
  assign old_ext  = full ? SUM_W'($signed(win_rd)) : '0;
  assign sum_nxt  = sum_r[ax_r] - old_ext + SUM_W'(val_r);
  assign div_start = (state_r == S_WRD);

  mcau_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (state_r == S_WRD),
    .wr_addr (win_addr),
    .wr_data (val_r),
    .rd_addr (win_addr),
    .rd_data (win_rd)
  );

  mcau_div #(
    .SUM_W  (SUM_W),
    .FILL_W (FILL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (fill_div),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCALE;
      end
      S_SCALE:   state_nxt = S_HARD;
      S_HARD:    state_nxt = soft_r ? S_SOFT : S_POST;
      S_SOFT:    state_nxt = S_SOFTSAT;
      S_SOFTSAT: state_nxt = S_POST;
      S_POST: begin
        if (avg_r) begin
          state_nxt = S_WIN;
        end else begin
          state_nxt = last ? S_OUT : S_SCALE;
        end
      end
      S_WIN: state_nxt = S_WRD;
      S_WRD: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) state_nxt = last ? S_OUT : S_SCALE;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      fill_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      unit_r      <= COEF_W'(65536);
      for (int a = 0; a < 3; a++) begin
        sum_r[a]    <= '0;
        offset_r[a] <= '0;
        gain_r[a]   <= COEF_W'(65536);
      end
    end else begin
      state_r <= state_nxt;

      if (accept) begin
        ax_r <= '0;
      end else if (axis_done && !last) begin
        ax_r <= ax_r + 1'b1;
      end

      if (state_r == S_WRD) begin
        sum_r[ax_r] <= sum_nxt;
      end

      // Fill and head move once per averaged sample, after the last axis.
      if ((state_r == S_DIV) && div_done && last) begin
        if (!full) fill_r <= fill_r + 1'b1;
        head_r <= (head_r == HEAD_W'(WINDOW - 1)) ? '0 : head_r + 1'b1;
      end

      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_UNIT_PER_LSB: unit_r      <= cfg_data[COEF_W-1:0];
          REG_OFFSET_X:     offset_r[0] <= $signed(cfg_data);
          REG_OFFSET_Y:     offset_r[1] <= $signed(cfg_data);
          REG_OFFSET_Z:     offset_r[2] <= $signed(cfg_data);
          REG_GAIN_X:       gain_r[0]   <= cfg_data[COEF_W-1:0];
          REG_GAIN_Y:       gain_r[1]   <= cfg_data[COEF_W-1:0];
          REG_GAIN_Z:       gain_r[2]   <= cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r[0] <= in_raw_x;
      raw_r[1] <= in_raw_y;
      raw_r[2] <= in_raw_z;
      avg_r    <= in_average_enable;
      hard_r   <= in_hard_iron_enable;
      soft_r   <= in_soft_iron_enable;
    end
    if ((state_r == S_SCALE) || (state_r == S_SOFT)) begin
      prod_r <= mul_p;
    end
    if (state_r == S_HARD) begin
      val_r <= hard_val;
    end else if (state_r == S_SOFTSAT) begin
      val_r <= soft_val;
    end
    if ((state_r == S_POST) && !avg_r) begin
      res_r[ax_r] <= val_r;
    end else if ((state_r == S_DIV) && div_done) begin
      res_r[ax_r] <= div_q;
    end
    if ((state_r == S_OUT) && out_free) begin
      out_x_r <= res_r[0];
      out_y_r <= res_r[1];
      out_z_r <= res_r[2];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_field_x = out_x_r;
  assign out_field_y = out_y_r;
  assign out_field_z = out_z_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("window fill count exceeds the window size");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= HEAD_W'(WINDOW - 1))
    else $error("window head out of range");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (ax_r <= AXIS_LAST))
    else $error("axis counter out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input accepted again while a sample is in progress");
`endif

endmodule
